FILE: hdl/gbq_pkg.sv
// Shared types and constants for the gain + biquad IIR block.
// No dependencies; every other file of the block but gbq_checker imports this package.
package gbq_pkg;

  localparam int FIELD_BITS   = 24;  // width of the sample/filtered fields
  localparam int COEF_BITS    = 24;  // width of gain and coefficient registers
  localparam int REG_IDX_BITS = 3;
  localparam int TAP_BITS     = 3;
  localparam int NUM_TAPS     = 5;

  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic [TAP_BITS-1:0]          tap_t;
  typedef logic [REG_IDX_BITS-1:0]      reg_idx_t;

  // Register map of the configuration port.
  localparam reg_idx_t REG_GAIN   = 3'd0;
  localparam reg_idx_t REG_ENABLE = 3'd1;
  localparam reg_idx_t REG_B0     = 3'd2;
  localparam reg_idx_t REG_B1     = 3'd3;
  localparam reg_idx_t REG_B2     = 3'd4;
  localparam reg_idx_t REG_A1     = 3'd5;
  localparam reg_idx_t REG_A2     = 3'd6;

  // Filter taps in the order the sequencer walks them.
  localparam tap_t TAP_B0 = 3'd0;
  localparam tap_t TAP_B1 = 3'd1;
  localparam tap_t TAP_B2 = 3'd2;
  localparam tap_t TAP_A1 = 3'd3;
  localparam tap_t TAP_A2 = 3'd4;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic issue;  // start a multiply this cycle
    logic first;  // product replaces the accumulator
    logic sub;    // product is subtracted
  } mac_ctrl_t;

  // Sequencer outputs towards the datapath.
  typedef struct packed {
    logic      in_ready;
    logic      sel_gain;     // operands are gain and input sample
    tap_t      tap;
    logic      load_gained;  // gained sample sits in the product register
    logic      finish;       // result moves into the output register
    mac_ctrl_t mac;
  } seq_ctrl_t;

endpackage

FILE: hdl/gbq_stream_if.sv
// Valid/ready stream interfaces for the sample input and the filtered output.
// Depends on gbq_pkg for the field type.
interface gbq_sample_if;
  import gbq_pkg::*;
  logic   valid;
  logic   ready;
  field_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gbq_filtered_if;
  import gbq_pkg::*;
  logic   valid;
  logic   ready;
  field_t filtered;
  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

FILE: hdl/gbq_mac.sv
// Shared multiply-accumulate unit: one registered multiplier and a wrapping accumulator.
// Depends on gbq_pkg for the control struct.
module gbq_mac #(
  parameter int B_BITS   = 24,
  parameter int ACC_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gbq_pkg::mac_ctrl_t             ctrl,
  input  gbq_pkg::coef_t                 op_a,
  input  logic signed [B_BITS-1:0]       op_b,
  output logic signed [gbq_pkg::COEF_BITS+B_BITS-1:0] prod,
  output logic signed [ACC_BITS-1:0]     acc
);
  import gbq_pkg::*;

  localparam int PROD_BITS = COEF_BITS + B_BITS;

  mac_ctrl_t                  ctrl_q;
  logic signed [ACC_BITS-1:0] term;
  logic signed [ACC_BITS-1:0] base;

  // The product wraps into the accumulator width, like the sum itself.
  assign term = ACC_BITS'(prod);
  assign base = ctrl_q.first ? '0 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl;
    end
    if (ctrl.issue) begin
      prod <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
    end
    if (ctrl_q.issue) begin
      acc <= ctrl_q.sub ? base - term : base + term;
    end
  end

endmodule

FILE: hdl/gbq_seq.sv
// Sequencer of the gain + biquad block: steps the shared MAC through gain and five taps.
// Depends on gbq_pkg for the tap codes and the control structs.
module gbq_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               filter_enable,
  input  logic               out_free,
  output gbq_pkg::seq_ctrl_t ctrl
);
  import gbq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GAIN  = 6'b000010,
    S_GWAIT = 6'b000100,
    S_MAC   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  tap_t   tap, tap_next;

  always_comb begin
    state_next = state;
    tap_next   = tap;
    ctrl       = '0;
    ctrl.tap   = tap;
    case (state)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (in_fire) state_next = S_GAIN;
      end
      S_GAIN: begin
        ctrl.sel_gain  = 1'b1;
        ctrl.mac.issue = 1'b1;
        ctrl.mac.first = 1'b1;
        state_next     = S_GWAIT;
      end
      S_GWAIT: begin
        ctrl.load_gained = 1'b1;
        tap_next         = TAP_B0;
        state_next       = filter_enable ? S_MAC : S_DONE;
      end
      S_MAC: begin
        ctrl.mac.issue = 1'b1;
        ctrl.mac.first = (tap == TAP_B0);
        ctrl.mac.sub   = (tap == TAP_A1) || (tap == TAP_A2);
        tap_next       = tap + tap_t'(1);
        if (tap == TAP_BITS'(NUM_TAPS - 1)) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        ctrl.finish = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= TAP_B0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

endmodule

FILE: hdl/gain_biquad_iir.sv
// Top level of the gain + direct-form-I biquad block: config registers, delay line, output.
// Depends on gbq_pkg, gbq_stream_if, gbq_mac and gbq_seq.
//
//   port      | dir | handshake      | payload
//   ----------+-----+----------------+---------------------------
//   samples   | in  | valid / ready  | sample   (24 b, signed)
//   results   | out | valid / ready  | filtered (24 b, signed)
//   cfg_*     | in  | cfg_we only    | cfg_index, cfg_data (24 b)
//
// A request runs through the single shared multiplier: one gain product, then five tap
// products when the filter is enabled.
// samples.ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next request is taken in.
// Reset (rst, synchronous) clears control, delay line and registers (gain to 1).
// A stalled output holds the sequencer in its last state until the register frees.
module gain_biquad_iir #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gbq_pkg::REG_IDX_BITS-1:0]    cfg_index,
  input  logic [gbq_pkg::COEF_BITS-1:0]       cfg_data,
  gbq_sample_if.sink                          samples,
  gbq_filtered_if.source                      results
);
  import gbq_pkg::*;

  localparam int B_BITS    = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam int ACC_BITS  = 2 * SAMPLE_BITS;
  localparam int PROD_BITS = COEF_BITS + B_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] state_word_t;

  coef_t       gain, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic        filter_enable;
  field_t      sample_q;
  state_word_t gained, x1, x2, y1, y2;
  state_word_t result;
  logic        out_valid;
  field_t      filtered_q;

  seq_ctrl_t                    ctrl;
  coef_t                        op_a;
  logic signed [B_BITS-1:0]     op_b;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [ACC_BITS-1:0]   acc;
  logic                         in_fire;
  logic                         out_free;

  assign in_fire  = samples.valid && ctrl.in_ready;
  assign out_free = !out_valid || results.ready;

  assign samples.ready    = ctrl.in_ready;
  assign results.valid    = out_valid;
  assign results.filtered = filtered_q;

  gbq_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .filter_enable (filter_enable),
    .out_free      (out_free),
    .ctrl          (ctrl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = coef_b0;
    op_b = B_BITS'(gained);
    if (ctrl.sel_gain) begin
      op_a = gain;
      op_b = B_BITS'(sample_q);
    end else begin
      case (ctrl.tap)
        TAP_B0: begin
          op_a = coef_b0;
          op_b = B_BITS'(gained);
        end
        TAP_B1: begin
          op_a = coef_b1;
          op_b = B_BITS'(x1);
        end
        TAP_B2: begin
          op_a = coef_b2;
          op_b = B_BITS'(x2);
        end
        TAP_A1: begin
          op_a = coef_a1;
          op_b = B_BITS'(y1);
        end
        TAP_A2: begin
          op_a = coef_a2;
          op_b = B_BITS'(y2);
        end
        default: begin
          op_a = coef_b0;
          op_b = B_BITS'(gained);
        end
      endcase
    end
  end

  gbq_mac #(
    .B_BITS   (B_BITS),
    .ACC_BITS (ACC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl.mac),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  // Q(SAMPLE_BITS-1) scaling: arithmetic shift, then keep SAMPLE_BITS bits.
  assign result = filter_enable ? state_word_t'(acc[ACC_BITS-2 -: SAMPLE_BITS]) : gained;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= coef_t'(1);
      filter_enable <= 1'b0;
      coef_b0       <= '0;
      coef_b1       <= '0;
      coef_b2       <= '0;
      coef_a1       <= '0;
      coef_a2       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:   gain          <= cfg_data;
        REG_ENABLE: filter_enable <= cfg_data[0];
        REG_B0:     coef_b0       <= cfg_data;
        REG_B1:     coef_b1       <= cfg_data;
        REG_B2:     coef_b2       <= cfg_data;
        REG_A1:     coef_a1       <= cfg_data;
        REG_A2:     coef_a2       <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.finish) begin
        out_valid <= 1'b1;
        if (filter_enable) begin
          x2 <= x1;
          x1 <= gained;
          y2 <= y1;
          y1 <= result;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) sample_q <= samples.sample;
    if (ctrl.load_gained) gained <= state_word_t'(prod);
    if (ctrl.finish) filtered_q <= FIELD_BITS'(result);
  end

endmodule

FILE: hdl/gbq_checker.sv
// Port-level checks of the gain + biquad block, bound to the top level.
// Depends only on the top level's ports; holds its own count of open requests.
module gbq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] filtered
);

  logic       in_acc, out_acc;
  logic [1:0] open_cnt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt <= 2'd0;
    end else begin
      open_cnt <= open_cnt + 2'(in_acc) - 2'(out_acc);
    end
  end

  // The block is busy for at least the gain multiply after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready ##1 !in_ready)
    else $error("input ready too soon after a request");

  // At most one request in work and one result waiting.
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_cnt <= 2'd2)
    else $error("too many open requests");

  // No result is delivered without a request behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> open_cnt != 2'd0)
    else $error("result without a request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("stalled result changed");

endmodule

bind gain_biquad_iir gbq_checker u_gbq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .filtered  (results.filtered)
);

FILE: dv/tb_top.sv
// Self-checking testbench for gain_biquad_iir: random and directed sample requests against
// a bit-exact gain and direct-form-I biquad predictor. Depends on gbq_pkg and gbq_stream_if.
module tb_top;
  import gbq_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int ACC_BITS = 2 * SAMPLE_BITS;
  localparam int HOLD_CYCLES = 400;
  localparam reg_idx_t REG_UNUSED = 3'd7;
  localparam coef_t COEF_MAX = 24'sh7FFFFF;
  localparam coef_t COEF_MIN = 24'sh800000;
  localparam field_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam field_t SAMPLE_MIN = 24'sh800000;

  logic clk;
  logic rst;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [COEF_BITS-1:0] cfg_data;

  gbq_sample_if sample_ch ();
  gbq_filtered_if result_ch ();

  gain_biquad_iir #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(sample_ch),
    .results(result_ch)
  );

  // Predictor copy of the configuration and the delay line.
  coef_t gain_q = coef_t'(1);
  logic filter_on = 1'b0;
  coef_t tap_b0 = '0;
  coef_t tap_b1 = '0;
  coef_t tap_b2 = '0;
  coef_t tap_a1 = '0;
  coef_t tap_a2 = '0;
  field_t x_prev1 = '0;
  field_t x_prev2 = '0;
  field_t y_prev1 = '0;
  field_t y_prev2 = '0;

  field_t pending_samples[$];
  field_t expected_filtered[$];
  int offered_count = 0;
  int taken_count = 0;
  int errors = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic field_t run_biquad(input field_t x);
    logic signed [ACC_BITS-1:0] prod;
    logic signed [ACC_BITS-1:0] acc;
    logic signed [ACC_BITS-1:0] scaled;
    field_t gained;
    field_t y;
    prod = ACC_BITS'(gain_q) * ACC_BITS'(x);
    gained = prod[SAMPLE_BITS-1:0];
    y = gained;
    if (filter_on) begin
      // All products are formed at the full accumulator width, so the sum wraps there.
      acc = ACC_BITS'(tap_b0) * ACC_BITS'(gained) + ACC_BITS'(tap_b1) * ACC_BITS'(x_prev1)
          + ACC_BITS'(tap_b2) * ACC_BITS'(x_prev2) - ACC_BITS'(tap_a1) * ACC_BITS'(y_prev1)
          - ACC_BITS'(tap_a2) * ACC_BITS'(y_prev2);
      scaled = acc >>> (SAMPLE_BITS - 1);
      y = scaled[SAMPLE_BITS-1:0];
      x_prev2 = x_prev1;
      x_prev1 = gained;
      y_prev2 = y_prev1;
      y_prev1 = y;
    end
    return y;
  endfunction

  function automatic field_t random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return '0;
        default: return field_t'(-1);
      endcase
    end else if (pick < 55) begin
      return field_t'($urandom);
    end
    return field_t'(int'($urandom_range(2000)) - 1000);
  endfunction

  function automatic coef_t random_coef();
    if ($urandom_range(1) == 1) begin
      return coef_t'($urandom);
    end
    // Coefficients below one half keep most filters from wrapping on every sample.
    return coef_t'(int'($urandom_range(1 << 22)) - (1 << 21));
  endfunction

  function automatic coef_t random_gain();
    case ($urandom_range(3))
      0: return coef_t'(int'($urandom_range(8)) - 4);
      1: return coef_t'($urandom);
      2: return coef_t'(1);
      default: return coef_t'(-1);
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [COEF_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_GAIN: gain_q = data;
      REG_ENABLE: filter_on = data[0];
      REG_B0: tap_b0 = data;
      REG_B1: tap_b1 = data;
      REG_B2: tap_b2 = data;
      REG_A1: tap_a1 = data;
      REG_A2: tap_a2 = data;
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || offered_count != taken_count ||
           expected_filtered.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic configure_phase(input int phase);
    logic [COEF_BITS-1:0] enable_word;
    enable_word = COEF_BITS'($urandom);
    enable_word[0] = ($urandom_range(3) != 0);
    if (phase == 0) begin
      write_reg(REG_GAIN, COEF_MAX);
      write_reg(REG_ENABLE, 24'd1);
      write_reg(REG_B0, COEF_MAX);
      write_reg(REG_B1, COEF_MAX);
      write_reg(REG_B2, COEF_MAX);
      write_reg(REG_A1, COEF_MAX);
      write_reg(REG_A2, COEF_MAX);
    end else if (phase == 1) begin
      write_reg(REG_GAIN, COEF_MIN);
      write_reg(REG_ENABLE, 24'd1);
      write_reg(REG_B0, COEF_MIN);
      write_reg(REG_B1, COEF_MIN);
      write_reg(REG_B2, COEF_MIN);
      write_reg(REG_A1, COEF_MIN);
      write_reg(REG_A2, COEF_MIN);
    end else begin
      write_reg(REG_GAIN, random_gain());
      write_reg(REG_ENABLE, enable_word);
      write_reg(REG_B0, random_coef());
      write_reg(REG_B1, random_coef());
      write_reg(REG_B2, random_coef());
      write_reg(REG_A1, random_coef());
      write_reg(REG_A2, random_coef());
    end
    finish_writes();
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Request driver: a request stays offered until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (sample_ch.valid && taken_count != offered_count) begin
    end else if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
      sample_ch.valid <= 1'b1;
      sample_ch.sample <= pending_samples.pop_front();
      offered_count++;
    end else begin
      sample_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    field_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: result %0d with no request outstanding", $time, result_ch.filtered);
          errors++;
        end else begin
          want = expected_filtered.pop_front();
          if (result_ch.filtered !== want) begin
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, want, result_ch.filtered);
            errors++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        expected_filtered.push_back(run_biquad(sample_ch.sample));
        taken_count++;
      end
    end
  end

  initial begin : stimulus
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 33;
    dst_idle_pct = 52;

    // Reset settings: unity gain, filter bypassed.
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back('0);
    pending_samples.push_back(field_t'(-1));
    pending_samples.push_back(field_t'(1));
    pending_samples.push_back(24'sh555555);
    pending_samples.push_back(24'shAAAAAA);
    wait_drained();

    // Gain overflow in both directions; a write to the unused index must change nothing.
    write_reg(REG_GAIN, COEF_MAX);
    write_reg(REG_UNUSED, 24'h123456);
    finish_writes();
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(field_t'(2));
    wait_drained();
    write_reg(REG_GAIN, COEF_MIN);
    finish_writes();
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(field_t'(-1));
    wait_drained();

    // Extreme taps drive the accumulator and the scaled result into wraparound.
    // The enable word has every bit set; only its lowest bit counts.
    write_reg(REG_GAIN, 24'd1);
    write_reg(REG_ENABLE, 24'hFFFFFF);
    write_reg(REG_B0, COEF_MAX);
    write_reg(REG_B1, COEF_MIN);
    write_reg(REG_B2, COEF_MAX);
    write_reg(REG_A1, COEF_MIN);
    write_reg(REG_A2, COEF_MAX);
    finish_writes();
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back('0);
    wait_drained();

    // Bypass with a wide enable word whose low bit is clear; the delay line must hold.
    write_reg(REG_ENABLE, 24'hFFFFFE);
    finish_writes();
    pending_samples.push_back(24'sh123456);
    pending_samples.push_back(SAMPLE_MIN);
    wait_drained();
    write_reg(REG_ENABLE, 24'd1);
    finish_writes();
    pending_samples.push_back(field_t'(7));
    pending_samples.push_back(field_t'(-7));
    wait_drained();

    for (phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        src_idle_pct = 33;
        dst_idle_pct = 52;
      end else if (phase < 8) begin
        src_idle_pct = 52;
        dst_idle_pct = 33;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      configure_phase(phase);
      repeat (100) pending_samples.push_back(random_sample());
      // The output side stops for a long stretch while requests keep coming.
      if (phase == 2 || phase == 9) begin
        hold_requests++;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
